// ===== design/srcc_pkg.sv =====
// Shared widths and types of the sparse range chunk coalescer.
// Used by the shared adder, the result stage and the top level; depends on nothing.
`timescale 1ns / 1ps

package srcc_pkg;

  // Byte addresses, lengths and totals.
  localparam int ADDR_W = 44;
  // Subtask counter width.
  localparam int CNT_W = 20;
  // Width of the shared adder; wide enough for signed sums of addresses and chunk limits.
  localparam int ALU_W = 48;

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] seg_offset;
    logic [ADDR_W-1:0] seg_length;
    logic [CNT_W-1:0]  subtask_index;
    logic              closes_subtask;
    logic [ADDR_W-1:0] total_bytes;
    logic              sparse_used;
    logic              last_of_run;
  } res_t;

  // Requests from the sequencer to the result stage.
  typedef struct packed {
    logic put;    // A new result is produced this cycle.
    logic flush;  // The current input is done; release the held result as its last.
  } seq_req_t;

endpackage

// ===== design/srcc_alu.sv =====
// Shared adder/subtractor of the coalescer, time-shared by the sequencer steps.
// Depends on srcc_pkg for its width.
`timescale 1ns / 1ps

module srcc_alu
  import srcc_pkg::*;
(
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  input  logic             sub_i,
  output logic [ALU_W-1:0] y_o
);

  // Two's complement add or subtract; callers read the top bit as the sign.
  always_comb begin
    if (sub_i) begin
      y_o = a_i - b_i;
    end else begin
      y_o = a_i + b_i;
    end
  end

endmodule

// ===== design/srcc_out_stage.sv =====
// Result staging of the coalescer: a hold register that waits to learn whether a
// result is the last of its input, followed by the output register. Depends on srcc_pkg.
`timescale 1ns / 1ps

module srcc_out_stage
  import srcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  seq_req_t req_i,
  input  res_t     res_i,
  output logic     ok_o,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_res_o
);

  logic hold_v_r;
  logic hold_v_nxt;
  res_t hold_r;
  res_t hold_nxt;
  logic outv_r;
  logic outv_nxt;
  res_t out_r;
  res_t out_nxt;
  logic out_free;

  // The output register can take a new transaction when it is empty or being read.
  assign out_free = !outv_r || out_ready;
  // A put or flush only has to move something when the hold register is full.
  assign ok_o = !hold_v_r || out_free;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    outv_nxt   = outv_r && !out_ready;
    out_nxt    = out_r;
    if (req_i.put && ok_o) begin
      // A newer result exists, so the held one is not the last.
      if (hold_v_r) begin
        out_nxt             = hold_r;
        out_nxt.last_of_run = 1'b0;
        outv_nxt            = 1'b1;
      end
      hold_nxt             = res_i;
      hold_nxt.last_of_run = 1'b0;
      hold_v_nxt           = 1'b1;
    end else if (req_i.flush && ok_o) begin
      // End of the input: the held result closes the run.
      if (hold_v_r) begin
        out_nxt             = hold_r;
        out_nxt.last_of_run = 1'b1;
        outv_nxt            = 1'b1;
      end
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      outv_r   <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      outv_r   <= outv_nxt;
    end
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = outv_r;
  assign out_res_o = out_r;

endmodule

// ===== design/sparse_range_chunk_coalescer.sv =====
// Top level of the sparse range chunk coalescer: configuration registers, sequencer,
// coalescing state. Depends on srcc_pkg, srcc_alu and srcc_out_stage.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   in       | in_valid / in_ready    | in_operation, in_range_offset, in_range_length
//   out      | out_valid / out_ready  | out_kind .. out_last_of_run (8 fields)
//   cfg      | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// The sequencer steps share the one adder and run one after another. A range is placed
// one chunk-sized piece at a time; a finish closes the open subtask and emits a summary.
// Reset is synchronous and clears the sequencer, the coalescing state and the
// configuration (to defaults). A stalled output only holds the sequencer when the held
// result must move into a full output register; the next input is taken while the last
// result still waits there.
`timescale 1ns / 1ps

module sparse_range_chunk_coalescer
  import srcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input transactions.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [ADDR_W-1:0]   in_range_offset,
  input  logic [ADDR_W-1:0]   in_range_length,
  // Result transactions.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [ADDR_W-1:0]   out_seg_offset,
  output logic [ADDR_W-1:0]   out_seg_length,
  output logic [CNT_W-1:0]    out_subtask_index,
  output logic                out_closes_subtask,
  output logic [ADDR_W-1:0]   out_total_bytes,
  output logic                out_sparse_used,
  output logic                out_last_of_run,
  // Configuration writes.
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data
);

  localparam int SHIFT_W = 6;
  localparam int GAP_W   = 16;
  localparam int LEN_W   = 46;  // Range length plus bridged gaps and overfill.
  localparam int FILL_W  = 41;  // Up to one chunk of 2^40 bytes.
  localparam int MAX_CHUNKS = 60;

  localparam logic [SHIFT_W-1:0] SHIFT_LOW   = 6'd9;
  localparam logic [SHIFT_W-1:0] SHIFT_HIGH  = 6'd40;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd23;
  localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd512;

  localparam logic [1:0] CFG_CHUNK_SHIFT = 2'd0;
  localparam logic [1:0] CFG_MERGE_GAP   = 2'd1;
  localparam logic [1:0] CFG_OBJECT_SIZE = 2'd2;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_FIN = 1'b1;

  localparam logic [1:0] KIND_SEG = 2'd0;
  localparam logic [1:0] KIND_SUM = 2'd1;
  localparam logic [1:0] KIND_REJ = 2'd2;

  typedef enum logic [20:0] {
    S_IDLE = 21'b000000000000000000001,
    S_CHK  = 21'b000000000000000000010,
    S_LOOP = 21'b000000000000000000100,
    S_G1   = 21'b000000000000000001000,
    S_G2   = 21'b000000000000000010000,
    S_DEC  = 21'b000000000000000100000,
    S_RM   = 21'b000000000000001000000,
    S_RM2  = 21'b000000000000010000000,
    S_BK1  = 21'b000000000000100000000,
    S_BK2  = 21'b000000000001000000000,
    S_PS   = 21'b000000000010000000000,
    S_PT   = 21'b000000000100000000000,
    S_PE   = 21'b000000001000000000000,
    S_PU   = 21'b000000010000000000000,
    S_PST  = 21'b000000100000000000000,
    S_PCK  = 21'b000001000000000000000,
    S_AD1  = 21'b000010000000000000000,
    S_AD2  = 21'b000100000000000000000,
    S_CL   = 21'b001000000000000000000,
    S_FIN  = 21'b010000000000000000000,
    S_DONE = 21'b100000000000000000000
  } state_t;

  // Chunk shift limited to the supported range.
  function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] s);
    logic [SHIFT_W-1:0] r;
    r = s;
    if (s < SHIFT_LOW) begin
      r = SHIFT_LOW;
    end else if (s > SHIFT_HIGH) begin
      r = SHIFT_HIGH;
    end
    return r;
  endfunction

  // x <= cap for a power-of-two cap: nothing at or above the cap bit, or exactly cap.
  function automatic logic le_cap(input logic [ALU_W-1:0] x, input logic [ALU_W-1:0] cap,
                                  input logic [ALU_W-1:0] mask);
    return ((x & mask) == '0) || (x == cap);
  endfunction

  // Configuration registers.
  logic [SHIFT_W-1:0] shift_r;
  logic [GAP_W-1:0]   mgap_r;
  logic [ADDR_W-1:0]  osize_r;

  // Sequencer and working registers of the current input.
  state_t             state_r, state_nxt;
  state_t             ret_r, ret_nxt;
  logic               op_r, op_nxt;
  logic [ADDR_W-1:0]  off_r, off_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [ADDR_W-1:0]  gap_r, gap_nxt;
  logic               near_r, near_nxt;
  logic [ALU_W-1:0]   room_r, room_nxt;
  logic [ALU_W-1:0]   s_r, s_nxt;
  logic               final_r, final_nxt;

  // Coalescing state kept across inputs.
  logic               pend_v_r, pend_v_nxt;
  logic [ADDR_W-1:0]  pend_off_r, pend_off_nxt;
  logic [ADDR_W-1:0]  pend_len_r, pend_len_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  total_r, total_nxt;

  logic [SHIFT_W-1:0] sh;
  logic [ALU_W-1:0]   cap_w;
  logic [ALU_W-1:0]   hi_mask;
  logic [ALU_W-1:0]   lim_w;
  logic [ALU_W-1:0]   p_w;
  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic               alu_sub;
  logic [ALU_W-1:0]   alu_y;
  logic               sparse;
  seq_req_t           req;
  res_t               put_res;
  res_t               out_res;
  logic               ok;

  // Capacity, the mask of bits at or above it, and the longest accepted range.
  assign sh      = clamp_shift(shift_r);
  assign cap_w   = ALU_W'(1) << sh;
  assign hi_mask = ~(cap_w - ALU_W'(1));
  assign lim_w   = ALU_W'(MAX_CHUNKS) << sh;

  // Piece being placed: the whole remaining range, or the room left in the subtask.
  assign p_w = final_r ? ALU_W'(len_r) : room_r;

  // Summary flag: total below the object size.
  assign sparse = alu_y[ALU_W-1];

  assign in_ready = (state_r == S_IDLE);

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
      mgap_r  <= GAP_RESET;
      osize_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CHUNK_SHIFT: shift_r <= cfg_data[SHIFT_W-1:0];
        CFG_MERGE_GAP:   mgap_r  <= cfg_data[GAP_W-1:0];
        CFG_OBJECT_SIZE: osize_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection of the shared adder for each sequencer step.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_CHK: begin
        alu_a = lim_w; alu_b = ALU_W'(len_r); alu_sub = 1'b1;
      end
      S_G1: begin
        alu_a = ALU_W'(pend_off_r); alu_b = ALU_W'(pend_len_r);
      end
      S_G2: begin
        alu_a = ALU_W'(off_r); alu_b = ALU_W'(gap_r); alu_sub = 1'b1;
      end
      S_RM: begin
        alu_a = cap_w; alu_b = ALU_W'(fill_r); alu_sub = 1'b1;
      end
      S_RM2: begin
        alu_a = room_r; alu_b = ALU_W'(gap_r); alu_sub = 1'b1;
      end
      S_BK1: begin
        alu_a = ALU_W'(off_r); alu_b = ALU_W'(gap_r); alu_sub = 1'b1;
      end
      S_BK2: begin
        alu_a = ALU_W'(len_r); alu_b = ALU_W'(gap_r);
      end
      S_PS: begin
        alu_a = ALU_W'(gap_r); alu_b = p_w;
      end
      S_PT: begin
        alu_a = ALU_W'(fill_r); alu_b = s_r;
      end
      S_PE: begin
        alu_a = ALU_W'(pend_len_r); alu_b = s_r;
      end
      S_PU: begin
        alu_a = ALU_W'(fill_r); alu_b = p_w;
      end
      S_AD1: begin
        alu_a = ALU_W'(off_r); alu_b = room_r;
      end
      S_AD2: begin
        alu_a = ALU_W'(len_r); alu_b = room_r; alu_sub = 1'b1;
      end
      S_CL: begin
        alu_a = ALU_W'(total_r); alu_b = ALU_W'(fill_r);
      end
      S_FIN: begin
        alu_a = ALU_W'(total_r); alu_b = ALU_W'(osize_r); alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  srcc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .y_o   (alu_y)
  );

  // Sequencer: at most one adder operation per step; steps that emit a result wait for room.
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    op_nxt       = op_r;
    off_nxt      = off_r;
    len_nxt      = len_r;
    gap_nxt      = gap_r;
    near_nxt     = near_r;
    room_nxt     = room_r;
    s_nxt        = s_r;
    final_nxt    = final_r;
    pend_v_nxt   = pend_v_r;
    pend_off_nxt = pend_off_r;
    pend_len_nxt = pend_len_r;
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    total_nxt    = total_r;
    req          = '0;
    put_res      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          off_nxt   = in_range_offset;
          len_nxt   = LEN_W'(in_range_length);
          state_nxt = S_CHK;
        end
      end
      // Sort out finish, empty and oversized inputs.
      S_CHK: begin
        if (op_r == OP_FIN) begin
          ret_nxt   = S_FIN;
          state_nxt = S_CL;
        end else if (len_r == '0) begin
          state_nxt = S_IDLE;
        end else if (alu_y[ALU_W-1]) begin
          req.put                = 1'b1;
          put_res.kind           = KIND_REJ;
          put_res.seg_offset     = off_r;
          put_res.seg_length     = len_r[ADDR_W-1:0];
          put_res.subtask_index  = cnt_r;
          put_res.total_bytes    = total_r;
          if (ok) begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_LOOP;
        end
      end
      // Top of the split loop: distance to the held segment.
      S_LOOP: begin
        if (pend_v_r) begin
          state_nxt = S_G1;
        end else begin
          gap_nxt   = '0;
          near_nxt  = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_G1: begin
        gap_nxt   = alu_y[ADDR_W-1:0];
        state_nxt = S_G2;
      end
      S_G2: begin
        gap_nxt   = alu_y[ADDR_W-1:0];
        near_nxt  = (alu_y[ADDR_W-1:GAP_W] == '0) && (alu_y[GAP_W-1:0] <= mgap_r);
        state_nxt = S_DEC;
      end
      // A remainder within one chunk is placed whole; a longer one is split.
      S_DEC: begin
        if (le_cap(ALU_W'(len_r), cap_w, hi_mask)) begin
          final_nxt = 1'b1;
          state_nxt = S_PS;
        end else begin
          state_nxt = S_RM;
        end
      end
      S_RM: begin
        room_nxt  = alu_y;
        state_nxt = S_RM2;
      end
      // Room is negative when the chunk shrank below the open subtask's fill.
      S_RM2: begin
        if (room_r == '0) begin
          ret_nxt   = S_LOOP;
          state_nxt = S_CL;
        end else if (near_r && (gap_r != '0) &&
                     (room_r[ALU_W-1] || (!alu_y[ALU_W-1] && (alu_y != '0)))) begin
          state_nxt = S_BK1;
        end else begin
          final_nxt = 1'b0;
          state_nxt = S_PS;
        end
      end
      // Pull the range back over the bridged gap.
      S_BK1: begin
        off_nxt   = alu_y[ADDR_W-1:0];
        state_nxt = S_BK2;
      end
      S_BK2: begin
        len_nxt   = alu_y[LEN_W-1:0];
        state_nxt = S_LOOP;
      end
      // Placement: gap plus piece, then try to extend the held segment.
      S_PS: begin
        s_nxt     = alu_y;
        state_nxt = S_PT;
      end
      S_PT: begin
        if (near_r && le_cap(alu_y, cap_w, hi_mask)) begin
          fill_nxt  = alu_y[FILL_W-1:0];
          state_nxt = S_PE;
        end else begin
          state_nxt = S_PU;
        end
      end
      S_PE: begin
        pend_len_nxt = alu_y[ADDR_W-1:0];
        state_nxt    = S_PCK;
      end
      // Start a new segment in the open subtask, or close it first.
      S_PU: begin
        if (!near_r && le_cap(alu_y, cap_w, hi_mask)) begin
          req.put               = pend_v_r;
          put_res.kind          = KIND_SEG;
          put_res.seg_offset    = pend_off_r;
          put_res.seg_length    = pend_len_r;
          put_res.subtask_index = cnt_r;
          put_res.total_bytes   = total_r;
          if (!pend_v_r || ok) begin
            pend_v_nxt   = 1'b1;
            pend_off_nxt = off_r;
            pend_len_nxt = p_w[ADDR_W-1:0];
            fill_nxt     = alu_y[FILL_W-1:0];
            state_nxt    = S_PCK;
          end
        end else begin
          ret_nxt   = S_PST;
          state_nxt = S_CL;
        end
      end
      S_PST: begin
        pend_v_nxt   = 1'b1;
        pend_off_nxt = off_r;
        pend_len_nxt = p_w[ADDR_W-1:0];
        fill_nxt     = p_w[FILL_W-1:0];
        state_nxt    = S_PCK;
      end
      // A full subtask is closed at once.
      S_PCK: begin
        if ((ALU_W'(fill_r) & hi_mask) != '0) begin
          ret_nxt   = S_AD1;
          state_nxt = S_CL;
        end else begin
          state_nxt = S_AD1;
        end
      end
      // Advance past the placed piece, or finish the input.
      S_AD1: begin
        if (final_r) begin
          state_nxt = S_DONE;
        end else begin
          off_nxt   = alu_y[ADDR_W-1:0];
          state_nxt = S_AD2;
        end
      end
      S_AD2: begin
        len_nxt   = alu_y[LEN_W-1:0];
        state_nxt = S_LOOP;
      end
      // Close the open subtask: add its fill and release the held segment.
      S_CL: begin
        req.put                = pend_v_r;
        put_res.kind           = KIND_SEG;
        put_res.seg_offset     = pend_off_r;
        put_res.seg_length     = pend_len_r;
        put_res.subtask_index  = cnt_r;
        put_res.closes_subtask = 1'b1;
        put_res.total_bytes    = alu_y[ADDR_W-1:0];
        if (!pend_v_r || ok) begin
          total_nxt = alu_y[ADDR_W-1:0];
          if (pend_v_r && (cnt_r != '1)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          pend_v_nxt   = 1'b0;
          pend_off_nxt = '0;
          pend_len_nxt = '0;
          fill_nxt     = '0;
          state_nxt    = ret_r;
        end
      end
      // Finish summary, then clear the list state.
      S_FIN: begin
        req.put               = 1'b1;
        put_res.kind          = KIND_SUM;
        put_res.subtask_index = (sparse && (cnt_r == '0)) ? CNT_W'(1) : cnt_r;
        put_res.total_bytes   = total_r;
        put_res.sparse_used   = sparse;
        if (ok) begin
          total_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      // Release the held result as the last of this input.
      S_DONE: begin
        req.flush = 1'b1;
        if (ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      pend_v_r   <= 1'b0;
      pend_off_r <= '0;
      pend_len_r <= '0;
      fill_r     <= '0;
      cnt_r      <= '0;
      total_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_off_r <= pend_off_nxt;
      pend_len_r <= pend_len_nxt;
      fill_r     <= fill_nxt;
      cnt_r      <= cnt_nxt;
      total_r    <= total_nxt;
    end
    op_r    <= op_nxt;
    off_r   <= off_nxt;
    len_r   <= len_nxt;
    gap_r   <= gap_nxt;
    near_r  <= near_nxt;
    room_r  <= room_nxt;
    s_r     <= s_nxt;
    final_r <= final_nxt;
  end

  srcc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (req),
    .res_i     (put_res),
    .ok_o      (ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res_o (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_seg_offset     = out_res.seg_offset;
  assign out_seg_length     = out_res.seg_length;
  assign out_subtask_index  = out_res.subtask_index;
  assign out_closes_subtask = out_res.closes_subtask;
  assign out_total_bytes    = out_res.total_bytes;
  assign out_sparse_used    = out_res.sparse_used;
  assign out_last_of_run    = out_res.last_of_run;

  // Fill only accumulates while a segment is held.
  assert property (@(posedge clk) disable iff (!rst_n) !pend_v_r |-> (fill_r == '0))
    else $error("subtask fill is nonzero without a held segment");

  // The subtask count only drops when a finish clears the list.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cnt_r < $past(cnt_r)) |-> $past(state_r == S_FIN))
    else $error("subtask count dropped outside a finish");

  // The summary step always follows a completed close.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_FIN) |-> !pend_v_r)
    else $error("finish summary reached with a segment still held");

  // Only segments can be followed by more results of the same input.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_last_of_run) |-> (out_kind == KIND_SEG))
    else $error("summary or rejection not marked as last of its input");

  // An accepted input, add or finish, moves straight to its range checks.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_valid && in_ready) |=> (state_r == S_CHK))
    else $error("accepted input did not start the sequencer");

endmodule
